@@ rtl/nms_3x3_local_max_core_defines.svh @@
// Assertion macros shared by the 3x3 non-maximum suppression RTL.
`ifndef NMS_3X3_LOCAL_MAX_CORE_DEFINES_SVH
`define NMS_3X3_LOCAL_MAX_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on clk and disabled while arst_n is low.
`define NMS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nms_3x3_local_max_core: same-cycle check failed");

// Next-cycle implication, checked on clk and disabled while arst_n is low.
`define NMS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nms_3x3_local_max_core: next-cycle check failed");

`else

`define NMS_ASSERT_IMP(lbl, ante, cons)
`define NMS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ rtl/nms_pkg.sv @@
// Package with payload types, register indexes and constants of the 3x3 NMS core.
package nms_pkg;

	localparam int PIX_W     = 8;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;
	localparam int ROW_OUT_W = 10;
	localparam int COL_OUT_W = 10;
	localparam int DIM_MIN   = 3;

	localparam int NMS_MAX_WIDTH  = 1024;
	localparam int NMS_MAX_HEIGHT = 1024;

	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(640);
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(480);

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	typedef struct packed {
		logic             mode;
		logic [PIX_W-1:0] pixel_value;
	} in_t;

	typedef struct packed {
		logic                 is_maximum;
		logic [PIX_W-1:0]     centre_value;
		logic [ROW_OUT_W-1:0] out_row;
		logic [COL_OUT_W-1:0] out_col;
		logic                 last_of_frame;
	} out_t;

endpackage

@@ rtl/nms_3x3_local_max_core.sv @@
// Top level of the streaming 3x3 non-maximum suppression core.
//
// Channel  Dir  Handshake              Payload
// in       in   in_valid / in_stall    in_data  (mode, pixel_value)
// out      out  out_valid / out_stall  out_data (is_maximum, centre_value, out_row,
//                                                 out_col, last_of_frame)
// cfg      in   cfg_we                 cfg_index, cfg_data (frame_width, frame_height)
//
// One item per clock sustained while out_stall is low; the result an item completes
// passes stage 1, stage 2 and the output register before it is offered.
// The rate is set by the single line-store RAM, read once and written once per item,
// with the previous write forwarded when two consecutive items hit the same column.
// Reset clears position counters, window and pipeline valids and loads 640 x 480;
// the line store is not cleared and takes no clearing pass.
// A stalled output holds the compare stage and the window; empty stages still take input.
`include "nms_3x3_local_max_core_defines.svh"

module nms_3x3_local_max_core import nms_pkg::*; #(
	parameter int MAX_WIDTH  = NMS_MAX_WIDTH,
	parameter int MAX_HEIGHT = NMS_MAX_HEIGHT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_t                 out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 2);
	localparam int KW = (CFG_W > WW) ? CFG_W : WW;
	localparam int KH = (CFG_W > HW) ? CFG_W : HW;
	localparam int LW = 2 * PIX_W;

	localparam logic [KW-1:0] W_MIN_K = KW'(DIM_MIN);
	localparam logic [KW-1:0] W_MAX_K = KW'(MAX_WIDTH);
	localparam logic [KH-1:0] H_MIN_K = KH'(DIM_MIN);
	localparam logic [KH-1:0] H_MAX_K = KH'(MAX_HEIGHT);

	typedef struct packed {
		logic                 emit;
		logic                 top_edge;
		logic                 bot_edge;
		logic                 left_edge;
		logic                 right_edge;
		logic                 last;
		logic [ROW_OUT_W-1:0] row;
		logic [COL_OUT_W-1:0] col;
	} ctl_t;

	// Configuration and geometry
	logic [CFG_W-1:0] frame_width_q;
	logic [CFG_W-1:0] frame_height_q;
	logic [KW-1:0]    fw_k;
	logic [KW-1:0]    w_k;
	logic [KH-1:0]    fh_k;
	logic [KH-1:0]    h_k;
	logic [WW-1:0]    w;
	logic [HW-1:0]    h;

	// Position and front-end step decode
	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic             drain;
	logic             act;
	logic             acc;
	logic             acc_go;
	logic [PIX_W-1:0] pix_eff;
	logic             col_zero;
	logic [RW-1:0]    row_off;
	logic [RW-1:0]    cr;
	logic [WW-1:0]    cc;
	logic [31:0]      cr_ext;
	logic [31:0]      cc_ext;
	logic [WW-1:0]    c_inc;
	logic             wrap;
	logic             frame_end;
	logic [CW-1:0]    col_n;
	logic [RW-1:0]    row_n;
	ctl_t             ctl_s0;

	// Pipeline
	logic             en_o;
	logic             en_2;
	logic             en_1;
	logic             valid_s1;
	logic             fwd_s1;
	logic [CW-1:0]    col_s1;
	logic [PIX_W-1:0] pix_s1;
	ctl_t             ctl_s1;
	logic [LW-1:0]    fwd_q;
	logic [LW-1:0]    ram_rdata;
	logic [LW-1:0]    line_rd;
	logic [LW-1:0]    ram_wdata;
	logic             ram_we;
	logic [PIX_W-1:0] top_s1;
	logic [PIX_W-1:0] mid_s1;
	logic [PIX_W-1:0] win_q [9];
	logic             valid_s2;
	ctl_t             ctl_s2;
	logic             is_max;
	logic             skip;
	out_t             result;
	logic             out_valid_q;
	out_t             out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		fw_k = KW'(frame_width_q);
		fh_k = KH'(frame_height_q);
		priority if (fw_k < W_MIN_K) begin
			w_k = W_MIN_K;
		end else if (fw_k > W_MAX_K) begin
			w_k = W_MAX_K;
		end else begin
			w_k = fw_k;
		end
		priority if (fh_k < H_MIN_K) begin
			h_k = H_MIN_K;
		end else if (fh_k > H_MAX_K) begin
			h_k = H_MAX_K;
		end else begin
			h_k = fh_k;
		end
		w = w_k[WW-1:0];
		h = h_k[HW-1:0];
	end

	// Stage enables: a stage moves when it is empty or the stage after it moves.
	assign en_o     = !out_valid_q || !out_stall;
	assign en_2     = !valid_s2 || en_o;
	assign en_1     = !valid_s1 || en_2;
	assign in_stall = !en_1;

	always_comb begin
		drain   = row_q >= RW'(h);
		act     = !(in_data.mode == MODE_FLUSH && !drain);
		acc     = in_valid && en_1;
		acc_go  = acc && act;
		pix_eff = drain ? '0 : in_data.pixel_value;

		// The reported centre is one row and one column behind the input; at column
		// zero it is the last column of the row before.
		col_zero = (col_q == '0);
		row_off  = col_zero ? RW'(2) : RW'(1);
		cr       = row_q - row_off;
		cc       = col_zero ? (w - WW'(1)) : (WW'(col_q) - WW'(1));
		cr_ext   = 32'(cr);
		cc_ext   = 32'(cc);

		ctl_s0.emit       = (row_q >= row_off) && (cr < RW'(h)) && (cc < w);
		ctl_s0.top_edge   = (cr == '0);
		ctl_s0.bot_edge   = (cr == RW'(h) - RW'(1));
		ctl_s0.left_edge  = (cc == '0);
		ctl_s0.right_edge = (cc == w - WW'(1));
		ctl_s0.last       = ctl_s0.bot_edge && ctl_s0.right_edge;
		ctl_s0.row        = cr_ext[ROW_OUT_W-1:0];
		ctl_s0.col        = cc_ext[COL_OUT_W-1:0];

		c_inc     = WW'(col_q) + WW'(1);
		wrap      = c_inc >= w;
		frame_end = row_q >= (RW'(h) + RW'(1));
		if (frame_end) begin
			col_n = '0;
			row_n = '0;
		end else if (wrap) begin
			col_n = '0;
			row_n = row_q + RW'(1);
		end else begin
			col_n = c_inc[CW-1:0];
			row_n = row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc_go) begin
			col_q <= col_n;
			row_q <= row_n;
		end
	end

	// Stage 1: line-store read data returns; the column is written back.
	assign ram_we = valid_s1 && en_2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (en_1) begin
			valid_s1 <= acc_go;
			fwd_s1   <= acc_go && ram_we && (col_q == col_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (acc_go) begin
			col_s1 <= col_q;
			pix_s1 <= pix_eff;
			ctl_s1 <= ctl_s0;
		end
		if (ram_we) begin
			fwd_q <= ram_wdata;
		end
	end

	nms_ram #(
		.WIDTH(LW),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_s1),
		.wdata (ram_wdata),
		.re    (acc_go),
		.raddr (col_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		line_rd   = fwd_s1 ? fwd_q : ram_rdata;
		top_s1    = line_rd[LW-1:PIX_W];
		mid_s1    = line_rd[PIX_W-1:0];
		ram_wdata = {mid_s1, pix_s1};
	end

	// The window shifts left as each item leaves stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (ram_we) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k*3]     <= win_q[k*3 + 1];
				win_q[k*3 + 1] <= win_q[k*3 + 2];
			end
			win_q[2] <= top_s1;
			win_q[5] <= mid_s1;
			win_q[8] <= pix_s1;
		end
	end

	// Stage 2: compare the centre against the neighbors that lie inside the image.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_2) begin
			valid_s2 <= valid_s1 && ctl_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_comb begin
		skip   = 1'b0;
		is_max = 1'b1;
		for (int r3 = 0; r3 < 3; r3++) begin
			for (int c3 = 0; c3 < 3; c3++) begin
				skip = (r3 == 0 && ctl_s2.top_edge) || (r3 == 2 && ctl_s2.bot_edge) ||
				       (c3 == 0 && ctl_s2.left_edge) || (c3 == 2 && ctl_s2.right_edge);
				if (!skip && (win_q[r3*3 + c3] > win_q[4])) begin
					is_max = 1'b0;
				end
			end
		end
		result.is_maximum    = is_max;
		result.centre_value  = win_q[4];
		result.out_row       = ctl_s2.row;
		result.out_col       = ctl_s2.col;
		result.last_of_frame = ctl_s2.last;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_o) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && en_o) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`NMS_ASSERT_NEXT(a_fwd_on_collision, acc_go && ram_we && (col_q == col_s1), fwd_s1)
	`NMS_ASSERT_NEXT(a_window_held, !en_2, $stable(win_q[4]) && $stable(win_q[8]))
	`NMS_ASSERT_IMP(a_out_from_s2, $rose(out_valid_q), $past(valid_s2))

endmodule

@@ rtl/nms_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
module nms_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// A read of the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
